@@ design/bpa_pkg.sv @@
// bpa_pkg: shared types, widths and helpers for the bitmap page allocator
// no dependencies; used by bitmap_page_allocator
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 4096;
  localparam int unsigned PAGE_BYTES_DEF = 4096;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned WORD_IDX_W  = 5;
  localparam int unsigned PAGE_CNT_RST = 4096;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NONE         = 3'd1,
    ST_MISALIGNED   = 3'd2,
    ST_RANGE        = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_e;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_e;

  // index of the lowest set bit, zero when none
  function automatic logic [WORD_IDX_W-1:0] first_set(input logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0]  iso;
    logic [WORD_IDX_W-1:0] idx;
    iso = w & (~w + {{(WORD_BITS-1){1'b0}}, 1'b1});
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (iso[i]) begin
        idx = idx | WORD_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

@@ design/bpa_ram.sv @@
// bpa_ram: generic single-write, single-read synchronous RAM
// registered read data; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ design/bitmap_page_allocator.sv @@
// bitmap_page_allocator: first-fit page frame allocator over a used/free bitmap
// depends on bpa_pkg and bpa_ram (bitmap words plus one summary bit per word)
// accept to result valid: misaligned or out-of-range frees go to S_DONE, others read their word
// in S_BEVAL; alloc scans summary words in S_SEVAL, then S_BEVAL, or S_DONE if none has a free page
// one request at a time, next accept in the cycle after the result loads; a held result stalls it
// reset: a clearing pass over every bitmap word marks every page used, no request taken
`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES  = bpa_pkg::MAX_PAGES_DEF,
  parameter int unsigned PAGE_BYTES = bpa_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bpa_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic                           kind_i,
  input  wire logic [bpa_pkg::ADDR_W-1:0]     phys_addr_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bpa_pkg::status_e                    status_o,
  output logic      [bpa_pkg::ADDR_W-1:0]     page_addr_o,
  output logic      [bpa_pkg::CNT_W-1:0]      free_count_o,
  output logic      [bpa_pkg::CNT_W-1:0]      used_count_o
);

  localparam int unsigned WB        = bpa_pkg::WORD_BITS;
  localparam int unsigned WB_W      = bpa_pkg::WORD_IDX_W;
  localparam int unsigned ADDR_W    = bpa_pkg::ADDR_W;
  localparam int unsigned CNT_W     = bpa_pkg::CNT_W;
  localparam int unsigned BMP_WORDS = (MAX_PAGES + WB - 1) / WB;
  localparam int unsigned SUM_WORDS = (BMP_WORDS + WB - 1) / WB;
  localparam int unsigned BA_W      = (BMP_WORDS > 1) ? $clog2(BMP_WORDS) : 1;
  localparam int unsigned SA_W      = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;
  localparam int unsigned OFF_W     = $clog2(PAGE_BYTES);
  localparam int unsigned PN_W      = ADDR_W - OFF_W;
  localparam int unsigned CNT_MAX   = (1 << CNT_W) - 1;
  localparam int unsigned LIMIT_CAP = (MAX_PAGES > CNT_MAX) ? CNT_MAX : MAX_PAGES;
  localparam int unsigned MW_A      = BA_W + WB_W + 1;
  localparam int unsigned MW_B      = CNT_W + 2;
  localparam int unsigned MW_C      = PN_W + 1;
  localparam int unsigned MW_AB     = (MW_A > MW_B) ? MW_A : MW_B;
  localparam int unsigned MW        = (MW_AB > MW_C) ? MW_AB : MW_C;

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SEVAL = 5'b00100,
    S_BEVAL = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // ones for bit positions whose unit index base+i lies below lim
  function automatic logic [WB-1:0] below_mask(input logic [MW-1:0] lim,
                                               input logic [MW-1:0] base);
    logic [MW-1:0] diff;
    logic [WB-1:0] ones;
    diff = lim - base;
    ones = '1;
    if (lim <= base) begin
      return '0;
    end else if (diff >= MW'(WB)) begin
      return ones;
    end else begin
      return ~(ones << diff[WB_W-1:0]);
    end
  endfunction

  state_e                  state_q, state_d;
  logic [BA_W-1:0]         clr_q, clr_d;
  logic [SA_W-1:0]         sidx_q, sidx_d;
  logic [BA_W-1:0]         word_q, word_d;
  logic [WB_W-1:0]         bit_q, bit_d;
  bpa_pkg::kind_e          kind_q, kind_d;
  logic [CNT_W-1:0]        page_count_q;
  logic [CNT_W-1:0]        free_cnt_q, free_cnt_d;
  bpa_pkg::status_e        res_status_q, res_status_d;
  logic [ADDR_W-1:0]       res_addr_q, res_addr_d;
  logic                    out_valid_q, out_valid_d;
  bpa_pkg::status_e        out_status_q;
  logic [ADDR_W-1:0]       out_addr_q;
  logic [CNT_W-1:0]        out_free_q;
  logic [CNT_W-1:0]        out_used_q;
  logic                    out_load;

  logic                    bmp_we, bmp_re;
  logic [BA_W-1:0]         bmp_waddr, bmp_raddr;
  logic [WB-1:0]           bmp_wdata, bmp_rdata;
  logic                    sum_we, sum_re;
  logic [SA_W-1:0]         sum_waddr, sum_raddr;
  logic [WB-1:0]           sum_wdata, sum_rdata;

  logic [CNT_W-1:0]        limit;
  logic [MW-1:0]           lim_words;
  logic                    in_fire;
  logic [PN_W-1:0]         pn;
  logic                    misaligned;
  logic                    out_of_range;
  logic [BA_W-1:0]         req_word;
  logic [WB-1:0]           sum_hit;
  logic [MW-1:0]           next_base;
  logic [WB-1:0]           bmp_free;
  logic [WB_W-1:0]         alloc_bit;
  logic [BA_W+WB_W-1:0]    alloc_page;
  logic [WB-1:0]           alloc_oh;
  logic [WB-1:0]           free_oh;
  logic [WB-1:0]           sbit_oh;
  logic [WB-1:0]           alloc_word;
  logic [CNT_W-1:0]        used_cnt;

  assign limit = (page_count_q > CNT_W'(LIMIT_CAP)) ? CNT_W'(LIMIT_CAP) : page_count_q;
  assign lim_words = (MW'(limit) + MW'(WB - 1)) >> WB_W;

  assign in_ready_o   = (state_q == S_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign pn           = phys_addr_i[ADDR_W-1:OFF_W];
  assign misaligned   = |phys_addr_i[OFF_W-1:0];
  assign out_of_range = MW'(pn) >= MW'(limit);
  assign req_word     = BA_W'(pn >> WB_W);

  assign sum_hit    = sum_rdata & below_mask(lim_words, MW'(sidx_q) << WB_W);
  assign next_base  = (MW'(sidx_q) + MW'(1)) << WB_W;
  assign bmp_free   = ~bmp_rdata & below_mask(MW'(limit), MW'(word_q) << WB_W);
  assign alloc_bit  = bpa_pkg::first_set(bmp_free);
  assign alloc_page = {word_q, alloc_bit};
  assign alloc_oh   = WB'(1) << alloc_bit;
  assign free_oh    = WB'(1) << bit_q;
  assign sbit_oh    = WB'(1) << WB_W'(word_q);
  assign alloc_word = bmp_rdata | alloc_oh;

  assign used_cnt = (limit > free_cnt_q) ? (limit - free_cnt_q) : '0;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    sidx_d       = sidx_q;
    word_d       = word_q;
    bit_d        = bit_q;
    kind_d       = kind_q;
    free_cnt_d   = free_cnt_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_load     = 1'b0;
    bmp_we       = 1'b0;
    bmp_waddr    = word_q;
    bmp_wdata    = bmp_rdata;
    bmp_re       = 1'b0;
    bmp_raddr    = word_q;
    sum_we       = 1'b0;
    sum_waddr    = SA_W'(word_q >> WB_W);
    sum_wdata    = sum_rdata;
    sum_re       = 1'b0;
    sum_raddr    = sidx_q;

    unique case (state_q)
      S_INIT: begin
        bmp_we    = 1'b1;
        bmp_waddr = clr_q;
        bmp_wdata = '1;
        sum_we    = (clr_q < BA_W'(SUM_WORDS));
        sum_waddr = clr_q[SA_W-1:0];
        sum_wdata = '0;
        clr_d     = clr_q + BA_W'(1);
        if (clr_q == BA_W'(BMP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          kind_d     = bpa_pkg::kind_e'(kind_i);
          res_addr_d = '0;
          if (bpa_pkg::kind_e'(kind_i) == bpa_pkg::KIND_ALLOC) begin
            sidx_d    = '0;
            sum_re    = 1'b1;
            sum_raddr = '0;
            state_d   = S_SEVAL;
          end else if (misaligned) begin
            res_status_d = bpa_pkg::ST_MISALIGNED;
            state_d      = S_DONE;
          end else if (out_of_range) begin
            res_status_d = bpa_pkg::ST_RANGE;
            state_d      = S_DONE;
          end else begin
            word_d    = req_word;
            bit_d     = WB_W'(pn);
            bmp_re    = 1'b1;
            bmp_raddr = req_word;
            sum_re    = 1'b1;
            sum_raddr = SA_W'(req_word >> WB_W);
            state_d   = S_BEVAL;
          end
        end
      end
      S_SEVAL: begin
        priority if (sum_hit != '0) begin
          word_d    = BA_W'({sidx_q, bpa_pkg::first_set(sum_hit)});
          bmp_re    = 1'b1;
          bmp_raddr = BA_W'({sidx_q, bpa_pkg::first_set(sum_hit)});
          state_d   = S_BEVAL;
        end else if (next_base < lim_words) begin
          sidx_d    = sidx_q + SA_W'(1);
          sum_re    = 1'b1;
          sum_raddr = sidx_q + SA_W'(1);
        end else begin
          res_status_d = bpa_pkg::ST_NONE;
          state_d      = S_DONE;
        end
      end
      S_BEVAL: begin
        state_d = S_DONE;
        if (kind_q == bpa_pkg::KIND_ALLOC) begin
          if (bmp_free == '0) begin
            res_status_d = bpa_pkg::ST_NONE;
          end else begin
            res_status_d = bpa_pkg::ST_OK;
            res_addr_d   = ADDR_W'({alloc_page, {OFF_W{1'b0}}});
            bmp_we       = 1'b1;
            bmp_wdata    = alloc_word;
            sum_we       = &alloc_word;
            sum_wdata    = sum_rdata & ~sbit_oh;
            if (free_cnt_q != '0) begin
              free_cnt_d = free_cnt_q - CNT_W'(1);
            end
          end
        end else begin
          if (!bmp_rdata[bit_q]) begin
            res_status_d = bpa_pkg::ST_ALREADY_FREE;
          end else begin
            res_status_d = bpa_pkg::ST_OK;
            bmp_we       = 1'b1;
            bmp_wdata    = bmp_rdata & ~free_oh;
            sum_we       = 1'b1;
            sum_wdata    = sum_rdata | sbit_oh;
            free_cnt_d   = free_cnt_q + CNT_W'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      clr_q        <= '0;
      free_cnt_q   <= '0;
      page_count_q <= CNT_W'(bpa_pkg::PAGE_CNT_RST);
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_cnt_q  <= free_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        page_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sidx_q       <= sidx_d;
    word_q       <= word_d;
    bit_q        <= bit_d;
    kind_q       <= kind_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_free_q   <= free_cnt_q;
      out_used_q   <= used_cnt;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign page_addr_o  = out_addr_q;
  assign free_count_o = out_free_q;
  assign used_count_o = out_used_q;

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (BMP_WORDS)
  ) u_bitmap_ram (
    .clk_i   (clk_i),
    .we_i    (bmp_we),
    .waddr_i (bmp_waddr),
    .wdata_i (bmp_wdata),
    .re_i    (bmp_re),
    .raddr_i (bmp_raddr),
    .rdata_o (bmp_rdata)
  );

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (SUM_WORDS)
  ) u_summary_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  // read-modify-write never overlaps a read of the bitmap
  a_no_rmw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(bmp_we && bmp_re && (state_q != S_INIT)))
    else $error("bitmap read and write in the same cycle");

  a_free_cnt_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_cnt_q != $past(free_cnt_q)) |-> ($past(state_q) == S_BEVAL))
    else $error("free count changed outside bitmap update");

  a_free_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CNT_W'(LIMIT_CAP))
    else $error("free count above page capacity");

  a_addr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_addr_q[OFF_W-1:0] == '0))
    else $error("allocated page address not aligned");

endmodule

`default_nettype wire

@@ tb/bitmap_page_allocator_tb.sv @@
// bitmap_page_allocator_tb: directed table and random request stream for the page allocator,
// each result checked against an in-bench bitmap predictor or a fixed expected result
// depends on bpa_pkg and bitmap_page_allocator
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS   = 1050;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] page_addr;
    logic [CNT_W-1:0]  free_count;
    logic [CNT_W-1:0]  used_count;
  } page_result_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_op_e;

  typedef struct {
    row_op_e           op;
    kind_e             kind;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  pages;
    bit                fixed;
    page_result_t      result;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              kind_i = 1'b0;
  logic [ADDR_W-1:0] phys_addr_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  status_e           status_o;
  logic [ADDR_W-1:0] page_addr_o;
  logic [CNT_W-1:0]  free_count_o;
  logic [CNT_W-1:0]  used_count_o;

  // predictor state
  bit [MAX_PAGES_DEF-1:0] used_map = '1;
  int unsigned            free_held = 0;
  logic [CNT_W-1:0]       page_limit = CNT_W'(PAGE_CNT_RST);

  page_result_t predicted_results[$];
  bit           fixed_now = 1'b0;
  page_result_t fixed_result = '0;

  int unsigned sent_count = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 0;
  bit          valid_up = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  bitmap_page_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .phys_addr_i  (phys_addr_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .page_addr_o  (page_addr_o),
    .free_count_o (free_count_o),
    .used_count_o (used_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic page_result_t predict_page_request(input logic k,
                                                        input logic [ADDR_W-1:0] a);
    page_result_t r;
    int unsigned  lim;
    int unsigned  pg;
    int unsigned  used;
    bit           hit;
    lim = (page_limit > MAX_PAGES_DEF) ? MAX_PAGES_DEF : page_limit;
    r = '0;
    r.status = ST_OK;
    hit = 1'b0;
    pg = 0;
    if (k == KIND_ALLOC) begin
      for (int p = 0; p < lim; p++) begin
        if (!hit && !used_map[p]) begin
          hit = 1'b1;
          pg = p;
        end
      end
      if (hit) begin
        used_map[pg] = 1'b1;
        if (free_held > 0) free_held--;
        r.page_addr = {pg[11:0], 12'h000};
      end else begin
        r.status = ST_NONE;
      end
    end else begin
      pg = a[23:12];
      if (a[11:0] != 12'h000) begin
        r.status = ST_MISALIGNED;
      end else if (pg >= lim) begin
        r.status = ST_RANGE;
      end else if (!used_map[pg]) begin
        r.status = ST_ALREADY_FREE;
      end else begin
        used_map[pg] = 1'b0;
        free_held++;
      end
    end
    used = (lim > free_held) ? lim - free_held : 0;
    r.free_count = free_held[CNT_W-1:0];
    r.used_count = used[CNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    page_result_t want;
    if (cfg_we_i) page_limit = cfg_wdata_i;
    if (rst_ni && in_valid_i && in_ready_o) begin
      want = predict_page_request(kind_i, phys_addr_i);
      if (fixed_now) want = fixed_result;
      predicted_results.push_back(want);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (predicted_results.size() == 0) begin
        $display("%0t: result with nothing pending, status %0d addr %h", $time, status_o,
                 page_addr_o);
        mismatch_count++;
      end else begin
        want = predicted_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          mismatch_count++;
        end
        if (page_addr_o !== want.page_addr) begin
          $display("%0t: page_addr expected %h actual %h", $time, want.page_addr, page_addr_o);
          mismatch_count++;
        end
        if (free_count_o !== want.free_count) begin
          $display("%0t: free_count expected %0d actual %0d", $time, want.free_count,
                   free_count_o);
          mismatch_count++;
        end
        if (used_count_o !== want.used_count) begin
          $display("%0t: used_count expected %0d actual %0d", $time, want.used_count,
                   used_count_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bitmap_page_allocator regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side stalls on stretches of its own, plus one long hold-off
  initial begin : receiver
    int unsigned stretch;
    int unsigned mode;
    stretch = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (250) @(posedge clk_i);
      end
      if (stretch == 0) begin
        mode = $urandom_range(0, 2);
        stretch = $urandom_range(10, 100);
      end
      stretch--;
      case (mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic issue(input kind_e k, input logic [ADDR_W-1:0] a, input bit fixed,
                       input page_result_t fr);
    int unsigned gap;
    in_valid_i <= 1'b1;
    kind_i <= k;
    phys_addr_i <= a;
    fixed_now <= fixed;
    fixed_result <= fr;
    valid_up = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  // sender pauses until every pending request has its result
  task automatic drain_requests();
    if (valid_up) begin
      in_valid_i <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk_i);
    while (results_checked < sent_count) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_page_count(input logic [CNT_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic stim_row_t req_row(input kind_e k, input logic [ADDR_W-1:0] a);
    stim_row_t r;
    r.op = ROW_REQ;
    r.kind = k;
    r.addr = a;
    r.pages = '0;
    r.fixed = 1'b0;
    r.result = '0;
    return r;
  endfunction

  function automatic stim_row_t fixed_row(input kind_e k, input logic [ADDR_W-1:0] a,
                                          input status_e st, input logic [ADDR_W-1:0] pa,
                                          input int unsigned fc, input int unsigned uc);
    stim_row_t r;
    r = req_row(k, a);
    r.fixed = 1'b1;
    r.result.status = st;
    r.result.page_addr = pa;
    r.result.free_count = CNT_W'(fc);
    r.result.used_count = CNT_W'(uc);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CNT_W-1:0] v);
    stim_row_t r;
    r = req_row(KIND_ALLOC, '0);
    r.op = ROW_CFG;
    r.pages = v;
    return r;
  endfunction

  initial begin : stimulus
    stim_row_t         directed_rows[$];
    int unsigned       remaining;
    int unsigned       phase_idx;
    int unsigned       pick;
    int unsigned       new_count;
    int unsigned       span;
    int unsigned       eff;
    int unsigned       n;
    logic [ADDR_W-1:0] addr;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    directed_rows.push_back(cfg_row(13'd4096));
    directed_rows.push_back(fixed_row(KIND_ALLOC, 24'h000000, ST_NONE, 24'h0, 0, 4096));
    directed_rows.push_back(fixed_row(KIND_FREE, 24'h000001, ST_MISALIGNED, 24'h0, 0, 4096));
    directed_rows.push_back(fixed_row(KIND_FREE, 24'hFFFFFF, ST_MISALIGNED, 24'h0, 0, 4096));
    directed_rows.push_back(fixed_row(KIND_FREE, 24'hFFF000, ST_OK, 24'h0, 1, 4095));
    directed_rows.push_back(fixed_row(KIND_FREE, 24'hFFF000, ST_ALREADY_FREE, 24'h0, 1, 4095));
    directed_rows.push_back(fixed_row(KIND_FREE, 24'h000000, ST_OK, 24'h0, 2, 4094));
    directed_rows.push_back(fixed_row(KIND_FREE, 24'h100000, ST_OK, 24'h0, 3, 4093));
    directed_rows.push_back(fixed_row(KIND_ALLOC, 24'hFFFFFF, ST_OK, 24'h0, 2, 4094));
    directed_rows.push_back(req_row(KIND_ALLOC, 24'h000000));
    directed_rows.push_back(fixed_row(KIND_ALLOC, 24'h000000, ST_OK, 24'hFFF000, 0, 4096));
    directed_rows.push_back(fixed_row(KIND_ALLOC, 24'h000000, ST_NONE, 24'h0, 0, 4096));
    directed_rows.push_back(fixed_row(KIND_FREE, 24'h000800, ST_MISALIGNED, 24'h0, 0, 4096));
    directed_rows.push_back(req_row(KIND_FREE, 24'h003000));
    directed_rows.push_back(req_row(KIND_FREE, 24'h009000));
    // shrink below a freed page: it stays counted but out of reach
    directed_rows.push_back(cfg_row(13'd8));
    directed_rows.push_back(req_row(KIND_FREE, 24'h008000));
    directed_rows.push_back(req_row(KIND_FREE, 24'h009000));
    directed_rows.push_back(req_row(KIND_ALLOC, 24'h000000));
    directed_rows.push_back(req_row(KIND_ALLOC, 24'h000000));
    directed_rows.push_back(cfg_row(13'd0));
    directed_rows.push_back(fixed_row(KIND_ALLOC, 24'h000000, ST_NONE, 24'h0, 1, 0));
    directed_rows.push_back(fixed_row(KIND_FREE, 24'h000000, ST_RANGE, 24'h0, 1, 0));
    // count above the page limit saturates
    directed_rows.push_back(cfg_row(13'd8191));
    directed_rows.push_back(req_row(KIND_FREE, 24'h000000));
    directed_rows.push_back(req_row(KIND_ALLOC, 24'h000000));
    directed_rows.push_back(req_row(KIND_FREE, 24'h7FF000));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == ROW_CFG) begin
        drain_requests();
        set_page_count(directed_rows[i].pages);
      end else begin
        issue(directed_rows[i].kind, directed_rows[i].addr, directed_rows[i].fixed,
              directed_rows[i].result);
      end
    end

    remaining = RANDOM_ITEMS;
    phase_idx = 0;
    while (remaining > 0) begin
      drain_requests();
      pick = $urandom_range(0, 9);
      if (phase_idx == 0) new_count = 16;
      else if (phase_idx == 1) new_count = 8191;
      else if (pick == 0) new_count = 0;
      else if (pick == 1) new_count = 4096;
      else if (pick == 2) new_count = $urandom_range(4097, 8191);
      else if (pick == 3) new_count = $urandom_range(65, 4095);
      else new_count = $urandom_range(1, 64);
      set_page_count(CNT_W'(new_count));
      eff = (new_count > MAX_PAGES_DEF) ? MAX_PAGES_DEF : new_count;
      span = $urandom_range(60, 140);
      if (span > remaining) span = remaining;
      for (n = 0; n < span; n++) begin
        if (phase_idx == 2 && n == 30) begin
          // long result stall while requests keep coming
          hold_req = 1'b1;
          burst_left = 80;
        end
        pick = $urandom_range(0, 99);
        addr = ADDR_W'($urandom);
        if (pick < 42) begin
          issue(KIND_ALLOC, addr, 1'b0, '0);
        end else if (pick < 82) begin
          addr[11:0] = 12'h000;
          if (eff != 0) addr[23:12] = 12'($urandom_range(0, eff - 1));
          issue(KIND_FREE, addr, 1'b0, '0);
        end else if (pick < 90) begin
          addr[11:0] = 12'h000;
          issue(KIND_FREE, addr, 1'b0, '0);
        end else begin
          issue(KIND_FREE, addr, 1'b0, '0);
        end
      end
      remaining -= span;
      phase_idx++;
    end

    drain_requests();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && predicted_results.size() == 0) begin
      $display("bitmap_page_allocator regression: pass");
    end else begin
      $display("bitmap_page_allocator regression: fail");
    end
    $finish;
  end

endmodule
